// ===== hw/rtl/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the cassette chunk parser.
// ----------------------------------------------------------------------------
package ccp_pkg;

   localparam int OFFSET_W = 24;

   // event kinds
   localparam logic [1:0] KIND_GAP  = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_BAUD = 2'd2;

   // chunk types
   localparam logic [1:0] TYPE_OTHER = 2'd0;
   localparam logic [1:0] TYPE_FUJI  = 2'd1;
   localparam logic [1:0] TYPE_BAUD  = 2'd2;
   localparam logic [1:0] TYPE_DATA  = 2'd3;

   // tags, first file byte in the low byte
   localparam logic [31:0] TAG_FUJI = 32'h494A5546;
   localparam logic [31:0] TAG_BAUD = 32'h64756162;
   localparam logic [31:0] TAG_DATA = 32'h61746164;

   localparam logic [2:0] HDR_LAST = 3'd7;

   // register word index (paddr[2])
   localparam logic CSR_IMAGE_SIZE = 1'b0;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                in_payload;
      logic [2:0]          hdr_count;
      logic [1:0]          chunk_type;
      logic [15:0]         payload_left;
   } ccp_state_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] value;
      logic        last;
   } ccp_event_type;

endpackage

// ===== hw/rtl/ccp_step.sv =====
// ----------------------------------------------------------------------------
// ccp_step
// Next-state and event logic for one image byte.
// ----------------------------------------------------------------------------
module ccp_step (
   input  ccp_pkg::ccp_state_type          state,
   input  logic [6:0][7:0]                 hdr,
   input  logic [7:0]                      image_byte,
   input  logic                            first_byte,
   input  logic [ccp_pkg::OFFSET_W-1:0]    image_size,
   output ccp_pkg::ccp_state_type          state_in,
   output logic                            hdr_we,
   output ccp_pkg::ccp_event_type          event_out
);

   ccp_pkg::ccp_state_type st;
   logic [15:0] size;
   logic [15:0] aux;
   logic [31:0] tag;
   logic [15:0] left_dec;

   always_comb begin
      st = state;
      if (first_byte) begin
         st.offset       = '0;
         st.in_payload   = 1'b0;
         st.hdr_count    = '0;
         st.chunk_type   = ccp_pkg::TYPE_OTHER;
         st.payload_left = '0;
      end

      tag      = {hdr[3], hdr[2], hdr[1], hdr[0]};
      size     = {hdr[5], hdr[4]};
      aux      = {image_byte, hdr[6]};
      left_dec = st.payload_left - 16'd1;

      state_in  = st;
      hdr_we    = 1'b0;
      event_out = '0;

      if (st.offset < image_size) begin
         state_in.offset = st.offset + ccp_pkg::OFFSET_W'(1);
         if (st.in_payload) begin
            state_in.payload_left = left_dec;
            state_in.in_payload   = (left_dec != 16'd0);
            if (st.chunk_type == ccp_pkg::TYPE_DATA) begin
               event_out.valid = 1'b1;
               event_out.kind  = ccp_pkg::KIND_BYTE;
               event_out.value = {8'd0, image_byte};
               event_out.last  = (left_dec == 16'd0);
            end
         end else if (st.hdr_count != ccp_pkg::HDR_LAST) begin
            hdr_we             = 1'b1;
            state_in.hdr_count = st.hdr_count + 3'd1;
         end else begin
            // header complete: byte 7 is the high byte of aux
            state_in.hdr_count    = '0;
            state_in.payload_left = size;
            state_in.in_payload   = (size != 16'd0);
            if (tag == ccp_pkg::TAG_FUJI) begin
               state_in.chunk_type = ccp_pkg::TYPE_FUJI;
            end else if (tag == ccp_pkg::TAG_BAUD) begin
               state_in.chunk_type = ccp_pkg::TYPE_BAUD;
               event_out.valid     = 1'b1;
               event_out.kind      = ccp_pkg::KIND_BAUD;
               event_out.value     = aux;
            end else if (tag == ccp_pkg::TAG_DATA) begin
               state_in.chunk_type = ccp_pkg::TYPE_DATA;
               event_out.valid     = 1'b1;
               event_out.kind      = ccp_pkg::KIND_GAP;
               event_out.value     = aux;
               event_out.last      = (size == 16'd0);
            end else begin
               state_in.chunk_type = ccp_pkg::TYPE_OTHER;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/cassette_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// cassette_chunk_parser
// Splits a tape image stream into chunks and emits gap, byte and baud events.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, and its event is then written to the result register.
// Throughput: one request per cycle while req_stall is low; the input register advances whenever
// the result register is empty or being taken.
// Reset: synchronous; clears parser state, image size and both valid flags.
// The header bytes are not cleared; each is written before it is read.
module cassette_chunk_parser (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_image_byte,
   input  logic        req_first_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [15:0] rsp_event_value,
   output logic        rsp_end_of_block,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [ccp_pkg::OFFSET_W-1:0] image_size_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_first_ff;

   ccp_pkg::ccp_state_type state_ff;
   ccp_pkg::ccp_state_type state_in;
   logic [6:0][7:0]        hdr_ff;
   logic                   hdr_we;
   ccp_pkg::ccp_event_type event_in;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_value_ff;
   logic        rsp_last_ff;

   logic advance;
   logic req_take;

   // configuration
   assign pready = 1'b1;
   assign prdata = (paddr[2] == ccp_pkg::CSR_IMAGE_SIZE) ? {8'd0, image_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == ccp_pkg::CSR_IMAGE_SIZE) begin
         image_size_ff <= pwdata[ccp_pkg::OFFSET_W-1:0];
      end
   end

   // pipeline control
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ccp_step u_step (
      .state      (state_ff),
      .hdr        (hdr_ff),
      .image_byte (s1_byte_ff),
      .first_byte (s1_first_ff),
      .image_size (image_size_ff),
      .state_in   (state_in),
      .hdr_we     (hdr_we),
      .event_out  (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_image_byte;
         s1_first_ff <= req_first_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hdr_we) begin
         hdr_ff[state_in.hdr_count - 3'd1] <= s1_byte_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && event_in.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && event_in.valid) begin
         rsp_kind_ff  <= event_in.kind;
         rsp_value_ff <= event_in.value;
         rsp_last_ff  <= event_in.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_value  = rsp_value_ff;
   assign rsp_end_of_block = rsp_last_ff;

   // checks
   a_hdr_outside_payload: assert property (@(posedge clock) disable iff (reset)
      state_ff.hdr_count != 3'd0 |-> !state_ff.in_payload)
      else $error("header count moved inside a payload");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.in_payload |-> state_ff.payload_left != 16'd0)
      else $error("payload active with nothing left");

   a_baud_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == ccp_pkg::KIND_BAUD |-> !rsp_last_ff)
      else $error("baud request marked end of block");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with room downstream");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds tape image bytes to the cassette chunk parser as well-formed chunk
// sequences with random content, plus truncated chunks, near-miss tags and
// noise. Gap, byte and baud events are predicted per accepted request and
// checked in order. The image size register is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SQUEEZE_CYCLES = 120;
   localparam int PHASE_BYTES = 245;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } tape_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic        last;
   } tape_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_image_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [15:0] rsp_event_value;
   logic        rsp_end_of_block;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   tape_byte_type  pending_bytes[$];
   tape_event_type expected_events[$];
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             squeeze_asks = 0;
   int             squeeze_seen = 0;
   int             squeeze_left = 0;
   int             stuck_cycles = 0;

   // parser state as predicted
   logic [23:0] cfg_image_size = '0;
   logic [7:0]  hdr_bytes [8];
   logic [23:0] tape_offset = '0;
   logic        in_payload = 1'b0;
   logic [2:0]  hdr_count = '0;
   logic [1:0]  chunk_kind = ccp_pkg::TYPE_OTHER;
   logic [15:0] bytes_left = '0;

   cassette_chunk_parser DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit predict_event(input logic [7:0] b, input logic first,
                                        output tape_event_type ev);
      logic [15:0] size;
      logic [31:0] tag;
      ev = '0;
      if (first) begin
         tape_offset = '0;
         in_payload  = 1'b0;
         hdr_count   = '0;
         chunk_kind  = ccp_pkg::TYPE_OTHER;
         bytes_left  = '0;
      end
      if (tape_offset >= cfg_image_size)
         return 1'b0;
      tape_offset = tape_offset + 24'd1;
      if (in_payload) begin
         bytes_left = bytes_left - 16'd1;
         if (bytes_left == 16'd0)
            in_payload = 1'b0;
         if (chunk_kind != ccp_pkg::TYPE_DATA)
            return 1'b0;
         ev.kind  = ccp_pkg::KIND_BYTE;
         ev.value = {8'h00, b};
         ev.last  = (bytes_left == 16'd0);
         return 1'b1;
      end
      hdr_bytes[hdr_count] = b;
      if (hdr_count != ccp_pkg::HDR_LAST) begin
         hdr_count = hdr_count + 3'd1;
         return 1'b0;
      end
      hdr_count  = '0;
      size       = {hdr_bytes[5], hdr_bytes[4]};
      tag        = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
      bytes_left = size;
      in_payload = (size != 16'd0);
      ev.value   = {hdr_bytes[7], hdr_bytes[6]};
      if (tag == ccp_pkg::TAG_FUJI) begin
         chunk_kind = ccp_pkg::TYPE_FUJI;
         return 1'b0;
      end
      if (tag == ccp_pkg::TAG_BAUD) begin
         chunk_kind = ccp_pkg::TYPE_BAUD;
         ev.kind    = ccp_pkg::KIND_BAUD;
         return 1'b1;
      end
      if (tag == ccp_pkg::TAG_DATA) begin
         chunk_kind = ccp_pkg::TYPE_DATA;
         ev.kind    = ccp_pkg::KIND_GAP;
         ev.last    = (size == 16'd0);
         return 1'b1;
      end
      chunk_kind = ccp_pkg::TYPE_OTHER;
      return 1'b0;
   endfunction

   // request side: predict on acceptance, then offer the next byte
   always @(posedge clock) begin : drive_requests
      tape_event_type ev;
      tape_byte_type  nxt;
      bit             offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (predict_event(req_image_byte, req_first_byte, ev))
               expected_events.push_back(ev);
         end
         if (!req_valid || !req_stall) begin
            offer = (pending_bytes.size() != 0) &&
                    ($urandom_range(0, 99) >= send_idle_pct);
            if (offer) begin
               nxt = pending_bytes.pop_front();
               req_image_byte <= nxt.data;
               req_first_byte <= nxt.first;
            end
            req_valid <= offer;
         end
      end
   end

   // result side stall: random, or a long hold-off when asked
   always @(posedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (squeeze_seen != squeeze_asks) begin
         squeeze_seen <= squeeze_asks;
         squeeze_left <= SQUEEZE_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (squeeze_left != 0) begin
         squeeze_left <= squeeze_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_events
      tape_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            fail_count++;
            if (fail_count < 100)
               $display("%0t: unexpected event kind=%0d value=%h last=%0d", $time,
                        rsp_event_kind, rsp_event_value, rsp_end_of_block);
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_kind !== want.kind || rsp_event_value !== want.value ||
                rsp_end_of_block !== want.last) begin
               fail_count++;
               if (fail_count < 100)
                  $display("%0t: expected %0d/%h/%0d got %0d/%h/%0d",
                           $time, want.kind, want.value, want.last,
                           rsp_event_kind, rsp_event_value, rsp_end_of_block);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("cassette_chunk_parser test failed");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic first);
      pending_bytes.push_back('{data: b, first: first});
   endtask

   task automatic add_header(input logic [31:0] tag, input logic [15:0] size,
                             input logic [15:0] aux, input logic first);
      add_byte(tag[7:0], first);
      add_byte(tag[15:8], 1'b0);
      add_byte(tag[23:16], 1'b0);
      add_byte(tag[31:24], 1'b0);
      add_byte(size[7:0], 1'b0);
      add_byte(size[15:8], 1'b0);
      add_byte(aux[7:0], 1'b0);
      add_byte(aux[15:8], 1'b0);
   endtask

   // one tape: a run of chunks, sometimes cut short
   task automatic add_tape();
      int          n_chunks;
      int          pick;
      int          n_payload;
      bit          broken;
      logic        first;
      logic [31:0] tag;
      logic [15:0] size;
      n_chunks = $urandom_range(1, 6);
      first = ($urandom_range(0, 3) != 0);
      for (int c = 0; c < n_chunks; c++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)       tag = ccp_pkg::TAG_DATA;
         else if (pick < 60)  tag = ccp_pkg::TAG_BAUD;
         else if (pick < 72)  tag = ccp_pkg::TAG_FUJI;
         else if (pick < 86) begin
            // near-miss: one bit off a known tag
            case ($urandom_range(0, 2))
               0:       tag = ccp_pkg::TAG_DATA;
               1:       tag = ccp_pkg::TAG_BAUD;
               default: tag = ccp_pkg::TAG_FUJI;
            endcase
            tag[5'($urandom_range(0, 31))] ^= 1'b1;
         end else
            tag = $urandom;
         pick = $urandom_range(0, 99);
         broken = 1'b0;
         if (pick < 80)       size = 16'($urandom_range(0, 12));
         else if (pick < 94)  size = 16'($urandom_range(13, 48));
         else begin
            size = 16'($urandom_range(0, 65535));
            broken = 1'b1;
         end
         if ($urandom_range(0, 99) < 4) begin
            // header cut off, next tape starts over when its first flag is set
            n_payload = $urandom_range(1, 7);
            for (int i = 0; i < n_payload; i++)
               add_byte(8'($urandom_range(0, 255)), (i == 0) ? first : 1'b0);
            return;
         end
         add_header(tag, size, 16'($urandom_range(0, 65535)), first);
         first = 1'b0;
         n_payload = broken ? $urandom_range(0, 16) : int'(size);
         for (int i = 0; i < n_payload; i++)
            add_byte(8'($urandom_range(0, 255)), 1'b0);
         if (broken)
            return;
      end
      if ($urandom_range(0, 99) < 10) begin
         n_payload = $urandom_range(1, 5);
         for (int i = 0; i < n_payload; i++)
            add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end
   endtask

   // wait until every request is taken and every event has come back
   task automatic settle();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_image_size(input logic [23:0] size);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {ccp_pkg::CSR_IMAGE_SIZE, 2'b00};
      pwdata  <= {8'($urandom), size};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_image_size = size;
      @(negedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 38;
            recv_idle_pct = 48;
         end
         1: begin
            send_idle_pct = 48;
            recv_idle_pct = 38;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   initial begin : stimulus
      logic [23:0] phase_size;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every event kind, empty data chunk, baud with payload
      set_idling(0);
      write_image_size(24'hFFFFFF);
      add_header(ccp_pkg::TAG_BAUD, 16'd1, 16'hFFFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_header(ccp_pkg::TAG_DATA, 16'd0, 16'h0000, 1'b0);
      add_header(ccp_pkg::TAG_DATA, 16'd1, 16'h8000, 1'b0);
      add_byte(8'hFF, 1'b0);
      settle();

      // zero image size: all ignored
      write_image_size(24'd0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      settle();

      // restart mid-header, then a payload cut off at the image end
      write_image_size(24'd10);
      add_byte(8'h64, 1'b1);
      add_byte(8'h61, 1'b0);
      add_header(ccp_pkg::TAG_DATA, 16'h8003, 16'h00AA, 1'b1);
      add_byte(8'h5A, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_byte(8'h3C, 1'b0);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0, 2, 5: phase_size = 24'hFFFFFF;
            4:       phase_size = 24'($urandom_range(1, 24));
            default: phase_size = 24'($urandom_range(9, 160));
         endcase
         write_image_size(phase_size);
         set_idling(p / 2);
         while (pending_bytes.size() < PHASE_BYTES)
            add_tape();
         // receiver holds off while requests keep coming
         if (p == 2 || p == 5)
            squeeze_asks++;
         settle();
      end

      if (fail_count == 0)
         $display("cassette_chunk_parser test passed");
      else
         $display("cassette_chunk_parser test failed");
      $finish;
   end

endmodule

// ===== cassette_chunk_parser.f =====
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_step.sv
hw/rtl/cassette_chunk_parser.sv
verif/tb_top.sv
